// ===== rtl/core/number_to_ascii_padded_formatter_unit_assert.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the number to ASCII formatter
// Clocked property checks that compile away when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef NUMBER_TO_ASCII_PADDED_FORMATTER_UNIT_ASSERT_SVH
`define NUMBER_TO_ASCII_PADDED_FORMATTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define NTOA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NTOA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NTOA_ASSERT(lbl, clk, rst_n, prop, msg)
`define NTOA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/ntoa_pkg.sv =====
// -----------------------------------------------------------------------------
// Number to ASCII formatter package
// Shared widths, radix mode codes, sequencer states and the digit encoder.
// -----------------------------------------------------------------------------
package ntoa_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned MAX_DIGITS_DEF = 64;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned PAD_W       = 7;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_A_BASE = 8'h37;

  typedef enum logic [OP_W-1:0] {
    OP_DEC = 2'd0,
    OP_HEX = 2'd1,
    OP_BIN = 2'd2,
    OP_BAD = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SCAN,
    ST_PAD,
    ST_DIGIT,
    ST_BAD
  } state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {4'b0000, d};
    end else begin
      c = ASCII_A_BASE + {4'b0000, d};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/number_to_ascii_padded_formatter_unit.sv =====
// -----------------------------------------------------------------------------
// Number to ASCII padded formatter
// Converts an unsigned number to decimal, hexadecimal or binary ASCII text.
// -----------------------------------------------------------------------------
// The slave channel takes one item: a number, a radix mode and a minimum
// width. The master channel returns the characters most significant first,
// one per item, with tlast on the final one. An unsupported mode returns a
// single item with tdata zero and tuser set.
// Decimal first runs a shift-and-add-3 converter over every value bit, then
// the decimal, hexadecimal and binary modes strip leading zero digits one per
// cycle through the same shifter, settle the padding (zeros are added in
// hexadecimal and binary only), then emit one character per cycle while the
// receiver is ready. Only one item is converted at a time. The last character
// sits in an output register, so the next item is accepted while it waits. A
// stalled receiver holds the sequencer while it emits. Reset empties the
// output register and returns the sequencer to idle.
// -----------------------------------------------------------------------------
`include "number_to_ascii_padded_formatter_unit_assert.svh"

module number_to_ascii_padded_formatter_unit #(
  parameter int unsigned VALUE_BITS = ntoa_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = ntoa_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: value[63:0], op[65:64], pad_width[72:66], zero fill.
  input  logic [ntoa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: char_code[7:0].
  output logic [ntoa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast,
  // Fields from bit 0: bad_mode.
  output logic                              m_axis_tuser
);

  import ntoa_pkg::*;

  localparam int unsigned NBCD  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W = 4 * NBCD;
  localparam int unsigned NHEX  = (VALUE_BITS + 3) / 4;
  localparam int unsigned HEX_W = 4 * NHEX;
  localparam int unsigned SH_W  = BCD_W;

  localparam logic [PAD_W-1:0] MaxDig  = PAD_W'(MAX_DIGITS);
  localparam logic [PAD_W-1:0] BitsCnt = PAD_W'(VALUE_BITS);
  localparam logic [PAD_W-1:0] HexCnt  = PAD_W'(NHEX);
  localparam logic [PAD_W-1:0] BcdCnt  = PAD_W'(NBCD);

  logic [VALUE_W-1:0]    in_value;
  logic [VALUE_BITS-1:0] val_trim;
  op_e                   in_op;
  logic [PAD_W-1:0]      in_pad;
  logic [PAD_W-1:0]      pad_clamp;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [SH_W-1:0]    sh_q, sh_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [PAD_W-1:0]   rem_q, rem_d;
  logic [PAD_W-1:0]   pad_q, pad_d;
  logic               trunc_q, trunc_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  logic               out_bad_q, out_bad_d;

  logic [3:0]         top_digit;
  logic               top_zero;
  logic [BCD_W-1:0]   bcd_adj;
  logic [BCD_W-1:0]   bcd_next;
  logic [SH_W-1:0]    sh_step;
  logic [PAD_W-1:0]   pad_need;
  logic               out_free;
  logic               emit;
  logic [CHAR_W-1:0]  emit_char;
  logic               emit_last;
  logic               emit_bad;

  assign in_value  = s_axis_tdata[VALUE_W-1:0];
  assign val_trim  = in_value[VALUE_BITS-1:0];
  assign in_op     = op_e'(s_axis_tdata[VALUE_W +: OP_W]);
  assign in_pad    = s_axis_tdata[VALUE_W+OP_W +: PAD_W];
  assign pad_clamp = (in_pad > MaxDig) ? MaxDig : in_pad;

  assign top_digit = (op_q == OP_BIN) ? {3'b000, sh_q[SH_W-1]} : sh_q[SH_W-1 -: 4];
  assign top_zero  = (top_digit == 4'd0);
  assign sh_step   = ((op_q == OP_BIN) || (state_q == ST_DABBLE)) ? (sh_q << 1) : (sh_q << 4);
  assign pad_need  = ((op_q != OP_DEC) && (pad_q > rem_q)) ? (pad_q - rem_q) : '0;
  assign out_free  = !out_valid_q || m_axis_tready;

  always_comb begin
    for (int i = 0; i < NBCD; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign bcd_next = {bcd_adj[BCD_W-2:0], sh_q[SH_W-1]};

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    sh_d          = sh_q;
    bcd_d         = bcd_q;
    rem_d         = rem_q;
    pad_d         = pad_q;
    trunc_d       = trunc_q;
    s_axis_tready = 1'b0;
    emit          = 1'b0;
    emit_char     = '0;
    emit_last     = 1'b0;
    emit_bad      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d    = in_op;
          pad_d   = pad_clamp;
          bcd_d   = '0;
          trunc_d = 1'b0;
          unique case (in_op)
            OP_DEC: begin
              sh_d    = SH_W'(val_trim) << (SH_W - VALUE_BITS);
              rem_d   = BitsCnt;
              state_d = ST_DABBLE;
            end
            OP_HEX: begin
              sh_d    = SH_W'(val_trim) << (SH_W - HEX_W);
              rem_d   = HexCnt;
              state_d = ST_SCAN;
            end
            OP_BIN: begin
              sh_d    = SH_W'(val_trim) << (SH_W - VALUE_BITS);
              rem_d   = BitsCnt;
              state_d = ST_SCAN;
            end
            OP_BAD: begin
              state_d = ST_BAD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_DABBLE: begin
        bcd_d = bcd_next;
        sh_d  = sh_step;
        rem_d = rem_q - 1'b1;
        if (rem_q == 1) begin
          sh_d    = SH_W'(bcd_next) << (SH_W - BCD_W);
          rem_d   = BcdCnt;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((rem_q > MaxDig) || ((rem_q > 1) && top_zero && !trunc_q)) begin
          trunc_d = trunc_q | ((rem_q > MaxDig) && !top_zero);
          sh_d    = sh_step;
          rem_d   = rem_q - 1'b1;
        end else begin
          pad_d   = pad_need;
          state_d = (pad_need != 0) ? ST_PAD : ST_DIGIT;
        end
      end
      ST_PAD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = ASCII_ZERO;
          pad_d     = pad_q - 1'b1;
          if (pad_q == 1) begin
            state_d = ST_DIGIT;
          end
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = digit_char(top_digit);
          emit_last = (rem_q == 1);
          sh_d      = sh_step;
          rem_d     = rem_q - 1'b1;
          if (rem_q == 1) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_BAD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_bad  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = emit || (out_valid_q && !m_axis_tready);
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;
    if (emit) begin
      out_char_d = emit_char;
      out_last_d = emit_last;
      out_bad_d  = emit_bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      trunc_q     <= trunc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    sh_q       <= sh_d;
    bcd_q      <= bcd_d;
    rem_q      <= rem_d;
    pad_q      <= pad_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_bad_q;

  `NTOA_ASSERT(a_digit_count_range, clk_i, rst_ni,
    (state_q == ST_DIGIT) |-> ((rem_q != 0) && (rem_q <= MaxDig)),
    "digit count out of range while emitting")
  `NTOA_ASSERT(a_pad_fits, clk_i, rst_ni,
    (state_q == ST_PAD) |-> (({1'b0, pad_q} + {1'b0, rem_q}) <= {1'b0, MaxDig}),
    "padded run exceeds digit capacity")
  `NTOA_ASSERT(a_last_ends_run, clk_i, rst_ni,
    (emit && emit_last) |=> (state_q == ST_IDLE),
    "sequencer busy after final character")
  `NTOA_ASSERT_ALWAYS(a_reset_empty, clk_i,
    !rst_ni |=> !m_axis_tvalid,
    "output valid during reset")

endmodule
